FILE: src/usb_control_endpoint_responder_core_assert.svh
// Assertion macros used by the checker file.
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_CORE_ASSERT_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_CORE_ASSERT_SVH

// Same-cycle implication.
`define UCER_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucer assertion failed");

// Next-cycle implication.
`define UCER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucer assertion failed");

`endif

FILE: src/ucer_pkg.sv
// ----------------------------------------------------------------------------
// ucer_pkg
// Types, codes and descriptor table for the endpoint-0 responder.
// ----------------------------------------------------------------------------
package ucer_pkg;

    typedef struct packed {
        logic        command;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  packet_bytes;
        logic [31:0] fifo_word;
        logic [5:0]  device_address;
        logic [1:0]  done_action;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ADDR   = 2'd2,
        KIND_DONE   = 2'd3
    } t_kind;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_REARM  = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;

    localparam logic [2:0] SRC_ZERO   = 3'd0;
    localparam logic [2:0] SRC_DEV    = 3'd1;
    localparam logic [2:0] SRC_CFG    = 3'd2;
    localparam logic [2:0] SRC_VENDOR = 3'd3;
    localparam logic [2:0] SRC_LANG   = 3'd4;
    localparam logic [2:0] SRC_STR1   = 3'd5;
    localparam logic [2:0] SRC_STR2   = 3'd6;

    localparam logic [7:0] RT_STD_OUT    = 8'h00;
    localparam logic [7:0] RT_STD_IN     = 8'h80;
    localparam logic [7:0] RT_VENDOR_IN  = 8'hc0;
    localparam logic [7:0] REQ_SET_ADDR  = 8'd5;
    localparam logic [7:0] REQ_GET_DESC  = 8'd6;
    localparam logic [7:0] REQ_SET_CFG   = 8'd9;
    localparam logic [15:0] VENDOR_LEN   = 16'h0104;
    localparam logic [15:0] LANG_EN_US   = 16'h0409;
    localparam logic [7:0] DT_DEVICE     = 8'd1;
    localparam logic [7:0] DT_CONFIG     = 8'd2;
    localparam logic [7:0] DT_STRING     = 8'd3;

    localparam int ROM_DEV  = 0;
    localparam int ROM_CFG  = 18;
    localparam int ROM_LANG = 50;
    localparam int ROM_STR1 = 54;
    localparam int ROM_STR2 = 72;

    localparam logic [8:0] LEN_DEV  = 9'd18;
    localparam logic [8:0] LEN_LANG = 9'd4;
    localparam logic [8:0] LEN_STR1 = 9'd18;
    localparam logic [8:0] LEN_STR2 = 9'd28;
    localparam logic [8:0] LEN_VEND = 9'd260;
    localparam int CFG_STORED = 32;

    // Config total-length byte (offset 2) is patched in at read time.
    localparam logic [7:0] DESC_ROM [0:99] = '{
        8'd18, 8'd1, 8'h10, 8'h01, 8'd0, 8'd0, 8'd0, 8'd64, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd2, 8'd0, 8'd1,
        8'd9, 8'd2, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'hc0, 8'd50,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'd0, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h01, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h82, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd4, 8'd3, 8'h09, 8'h04,
        8'd18, 8'd3, 8'h73, 8'd0, 8'h74, 8'd0, 8'h72, 8'd0, 8'h69, 8'd0,
        8'h6e, 8'd0, 8'h67, 8'd0, 8'h20, 8'd0, 8'h31, 8'd0,
        8'd28, 8'd3, 8'h73, 8'd0, 8'h65, 8'd0, 8'h63, 8'd0, 8'h6f, 8'd0,
        8'h6e, 8'd0, 8'h64, 8'd0, 8'h20, 8'd0, 8'h73, 8'd0, 8'h74, 8'd0,
        8'h72, 8'd0, 8'h69, 8'd0, 8'h6e, 8'd0, 8'h67, 8'd0
    };

    function automatic logic [7:0] src_byte(input logic [2:0] src, input logic [9:0] off,
                                            input logic [7:0] cfg_lo);
        logic [7:0] b;
        b = 8'd0;
        case (src)
            SRC_DEV:    if (off < 10'd18) b = DESC_ROM[7'(off) + 7'(ROM_DEV)];
            SRC_CFG: begin
                if (off == 10'd2) b = cfg_lo;
                else if (off < 10'(CFG_STORED)) b = DESC_ROM[7'(off) + 7'(ROM_CFG)];
            end
            SRC_VENDOR: if (off == 10'd0) b = 8'd2;
            SRC_LANG:   if (off < 10'd4) b = DESC_ROM[7'(off) + 7'(ROM_LANG)];
            SRC_STR1:   if (off < 10'd18) b = DESC_ROM[7'(off) + 7'(ROM_STR1)];
            SRC_STR2:   if (off < 10'd28) b = DESC_ROM[7'(off) + 7'(ROM_STR2)];
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

    typedef struct packed {
        logic  take_req;
        logic  enqueue;
        logic  start_head;
        logic  pop;
        logic  load_hdr;
        logic  next_word;
        logic  commit;
        logic  emit;
        t_kind kind;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic is_service;
        logic is_setaddr;
        logic enq_ok;
        logic q_empty;
        logic q_one;
        logic finished;
        logic pkt_zero;
        logic last_word;
        logic out_free;
    } t_sts;

endpackage

FILE: src/ucer_ctrl.sv
// ----------------------------------------------------------------------------
// ucer_ctrl
// Sequencer: decodes, queues and walks each reply one result per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ucer_ctrl
    import ucer_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DEC  = 6'b000010,
        ST_ADDR = 6'b000100,
        ST_HDR  = 6'b001000,
        ST_WORD = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_go, n_go;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_go    = r_go;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = ST_DEC;
                end
            end
            ST_DEC: begin
                if (i_sts.is_service) begin
                    if (i_sts.q_empty)       n_state = ST_IDLE;
                    else if (i_sts.finished) n_state = ST_DONE;
                    else                     n_state = ST_HDR;
                end else if (i_sts.is_setaddr) begin
                    o_cmd.enqueue    = i_sts.enq_ok;
                    o_cmd.start_head = i_sts.enq_ok && i_sts.q_empty;
                    n_go             = i_sts.enq_ok && i_sts.q_empty;
                    n_state          = ST_ADDR;
                end else if (i_sts.enq_ok) begin
                    o_cmd.enqueue    = 1'b1;
                    o_cmd.start_head = i_sts.q_empty;
                    n_state          = i_sts.q_empty ? ST_HDR : ST_IDLE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADDR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ADDR;
                    o_cmd.last = !r_go;
                    n_state    = r_go ? ST_HDR : ST_IDLE;
                end
            end
            ST_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = KIND_HEADER;
                    o_cmd.load_hdr = 1'b1;
                    o_cmd.last     = i_sts.pkt_zero;
                    n_state        = i_sts.pkt_zero ? ST_IDLE : ST_WORD;
                end
            end
            ST_WORD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_DATA;
                    o_cmd.last = i_sts.last_word;
                    if (i_sts.last_word) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.next_word = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.kind       = KIND_DONE;
                    o_cmd.last       = i_sts.q_one;
                    o_cmd.pop        = 1'b1;
                    o_cmd.start_head = !i_sts.q_one;
                    n_state          = i_sts.q_one ? ST_IDLE : ST_HDR;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

endmodule

FILE: src/ucer_dpath.sv
// ----------------------------------------------------------------------------
// ucer_dpath
// Request decode, reply queue, packet offset tracking and output register.
// ----------------------------------------------------------------------------
module ucer_dpath
    import ucer_pkg::*;
#(
    parameter int QUEUE_DEPTH       = 4,
    parameter int MAX_PACKET_BYTES  = 64,
    parameter int CONFIG_DESC_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = ((QW > CW) ? QW : CW) + 1;
    localparam int WW = $clog2((MAX_PACKET_BYTES + 3) / 4);

    t_in_item  r_req;
    logic [2:0] r_q_src [QUEUE_DEPTH];
    logic [8:0] r_q_len [QUEUE_DEPTH];
    logic [1:0] r_q_act [QUEUE_DEPTH];
    logic [QW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [8:0]    r_off;
    logic          r_short;   // last packet sent was short: reply finished
    logic [6:0]    r_pb;
    logic [WW-1:0] r_w;
    logic          r_out_valid;
    t_out_item     r_out;

    // decode
    logic       is_setaddr, is_setcfg, is_vendor, is_getdesc;
    logic       enq_req;
    logic [2:0] enq_src;
    logic [8:0] enq_len;
    logic [1:0] enq_act;
    logic [8:0] desc_size;
    logic [7:0] dtype, didx;

    assign dtype      = r_req.request_value[15:8];
    assign didx       = r_req.request_value[7:0];
    assign is_setaddr = (r_req.request_type == RT_STD_OUT) && (r_req.request_code == REQ_SET_ADDR);
    assign is_setcfg  = (r_req.request_type == RT_STD_OUT) && (r_req.request_code == REQ_SET_CFG);
    assign is_vendor  = (r_req.request_type == RT_VENDOR_IN)
                        && (r_req.request_length == VENDOR_LEN);
    assign is_getdesc = (r_req.request_type == RT_STD_IN) && (r_req.request_code == REQ_GET_DESC);

    always_comb begin
        enq_req   = 1'b0;
        enq_src   = SRC_ZERO;
        enq_act   = ACT_NONE;
        desc_size = 9'd0;
        if (is_setaddr || is_setcfg) begin
            enq_req = 1'b1;
        end else if (is_vendor) begin
            enq_req   = 1'b1;
            enq_src   = SRC_VENDOR;
            enq_act   = ACT_STATUS;
            desc_size = LEN_VEND;
        end else if (is_getdesc) begin
            enq_act = ACT_REARM;
            if (dtype == DT_DEVICE) begin
                enq_req = 1'b1; enq_src = SRC_DEV; desc_size = LEN_DEV;
            end else if (dtype == DT_CONFIG) begin
                enq_req = 1'b1; enq_src = SRC_CFG; desc_size = 9'(CONFIG_DESC_BYTES);
            end else if (dtype == DT_STRING) begin
                if (r_req.request_index == 16'd0) begin
                    enq_req = 1'b1; enq_src = SRC_LANG; desc_size = LEN_LANG;
                end else if (r_req.request_index == LANG_EN_US && didx == 8'd1) begin
                    enq_req = 1'b1; enq_src = SRC_STR1; desc_size = LEN_STR1;
                end else if (r_req.request_index == LANG_EN_US && didx == 8'd2) begin
                    enq_req = 1'b1; enq_src = SRC_STR2; desc_size = LEN_STR2;
                end
            end
        end
        // vendor length equals wLength, so clamping is a no-op there
        enq_len = ({7'd0, desc_size} > r_req.request_length) ? r_req.request_length[8:0]
                                                              : desc_size;
    end

    // queue pointers
    logic [SW-1:0] tail_sum;
    logic [QW-1:0] tail_idx, head_nxt;
    logic          q_full;

    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail_idx = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : QW'(tail_sum);
    assign head_nxt = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
    assign q_full   = (r_count == CW'(QUEUE_DEPTH));

    // current packet
    logic [2:0] h_src;
    logic [8:0] h_len, rem;
    logic [1:0] h_act;
    logic [6:0] cur_pb;

    assign h_src  = r_q_src[r_head];
    assign h_len  = r_q_len[r_head];
    assign h_act  = r_q_act[r_head];
    assign rem    = (h_len > r_off) ? h_len - r_off : 9'd0;
    assign cur_pb = (rem < 9'(MAX_PACKET_BYTES)) ? rem[6:0] : 7'(MAX_PACKET_BYTES);

    logic [31:0] word;
    logic [6:0]  pos;
    always_comb begin
        word = 32'd0;
        pos  = 7'd0;
        for (int b = 0; b < 4; b++) begin
            pos = 7'({r_w, 2'(b)});
            if (pos < r_pb)
                word[8*b +: 8] = src_byte(h_src, 10'(r_off) + 10'(pos),
                                          8'(CONFIG_DESC_BYTES));
        end
    end

    t_out_item n_out;
    always_comb begin
        n_out      = '0;
        n_out.kind = i_cmd.kind;
        n_out.last = i_cmd.last;
        case (i_cmd.kind)
            KIND_HEADER: n_out.packet_bytes   = cur_pb;
            KIND_DATA:   n_out.fifo_word      = word;
            KIND_ADDR:   n_out.device_address = r_req.request_value[5:0];
            KIND_DONE:   n_out.done_action    = h_act;
            default:     n_out.fifo_word      = 32'd0;
        endcase
    end

    assign o_sts.is_service = r_req.command;
    assign o_sts.is_setaddr = is_setaddr;
    assign o_sts.enq_ok     = enq_req && !q_full;
    assign o_sts.q_empty    = (r_count == '0);
    assign o_sts.q_one      = (r_count == CW'(1));
    assign o_sts.finished   = r_short;
    assign o_sts.pkt_zero   = (cur_pb == 7'd0);
    assign o_sts.last_word  = (8'({r_w, 2'b00}) + 8'd4) >= {1'b0, r_pb};
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) r_req <= i_in_data;
        if (i_cmd.enqueue) begin
            r_q_src[tail_idx] <= enq_src;
            r_q_len[tail_idx] <= enq_len;
            r_q_act[tail_idx] <= enq_act;
        end
        if (i_cmd.load_hdr) r_pb <= cur_pb;
        if (i_cmd.load_hdr) r_w <= '0;
        else if (i_cmd.next_word) r_w <= r_w + WW'(1);
        if (i_cmd.emit) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_short     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case ({i_cmd.enqueue, i_cmd.pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
            if (i_cmd.pop) r_head <= head_nxt;
            if (i_cmd.start_head) begin
                r_off   <= '0;
                r_short <= 1'b0;
            end else if (i_cmd.load_hdr && cur_pb == 7'd0) begin
                r_short <= 1'b1;
            end else if (i_cmd.commit) begin
                r_off   <= r_off + 9'(r_pb);
                r_short <= (r_pb < 7'(MAX_PACKET_BYTES));
            end
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/usb_control_endpoint_responder_core.sv
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder_core
// Endpoint-0 responder: one request is taken when the block is idle; it is
// decoded in the next cycle and its results then leave one per cycle through
// a registered output (fewer when the output stalls). A request yields at most
// an address update or done, a header and 16 FIFO words.
// Replies wait in a QUEUE_DEPTH-entry queue; a request finding it full is
// not queued.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder_core
    import ucer_pkg::*;
#(
    parameter int QUEUE_DEPTH       = 4,
    parameter int MAX_PACKET_BYTES  = 64,
    parameter int CONFIG_DESC_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd cmd;
    t_sts sts;

    ucer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ucer_dpath #(
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .MAX_PACKET_BYTES  (MAX_PACKET_BYTES),
        .CONFIG_DESC_BYTES (CONFIG_DESC_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: src/ucer_checker.sv
// ----------------------------------------------------------------------------
// ucer_checker
// Port-level checks for the endpoint-0 responder.
// ----------------------------------------------------------------------------
`include "usb_control_endpoint_responder_core_assert.svh"

module ucer_checker
    import ucer_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    `UCER_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `UCER_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `UCER_ASSERT_NOW(a_pkt_size, i_clk, i_rst_n, o_out_valid && o_out_data.kind == KIND_HEADER, o_out_data.packet_bytes <= 7'(MAX_PACKET_BYTES))
    `UCER_ASSERT_NOW(a_word_only_data, i_clk, i_rst_n, o_out_valid && o_out_data.kind != KIND_DATA, o_out_data.fifo_word == 32'd0)

endmodule

bind usb_control_endpoint_responder_core ucer_checker #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
) u_ucer_checker (.*);
